FILE: src/lrpt_pkg.sv
// Package for the least-requested peer tracker.
// Holds command and status codes and the fixed field widths.
// It has no dependencies.
package lrpt_pkg;

   localparam int PEER_BITS    = 6;
   localparam int PEER_IDS     = 64;
   localparam int LEN_OUT_BITS = 7;

   localparam logic CMD_REGISTER = 1'b0;
   localparam logic CMD_REQUEST  = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

endpackage

FILE: src/lrpt_list_ram.sv
// Swarm list memory: one write port, one registered read port.
// It depends on lrpt_pkg for the peer width.
// Its entries are undefined until written.
module lrpt_list_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                           clock,
   input  logic                           we,
   input  logic [AW-1:0]                  waddr,
   input  logic [lrpt_pkg::PEER_BITS-1:0] wdata,
   input  logic [AW-1:0]                  raddr,
   output logic [lrpt_pkg::PEER_BITS-1:0] rdata
);
   import lrpt_pkg::*;

   logic [PEER_BITS-1:0] mem [DEPTH];
   logic [PEER_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/lrpt_vram.sv
// Memory with one valid bit per entry, so that it reads as zero after reset.
// One write port and one registered read port; no package is needed.
module lrpt_vram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rd_ff;
   logic             rvalid_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (we) begin
            valid_ff[waddr] <= 1'b1;
         end
         rvalid_ff <= valid_ff[raddr];
      end
   end

   assign rdata = rvalid_ff ? rd_ff : '0;

endmodule

FILE: src/least_requested_peer_tracker.sv
// Top level of the least-requested peer tracker: sequencer and length store.
// It depends on lrpt_pkg, lrpt_list_ram and lrpt_vram.
//
// Channel   Handshake        Payload
// request   start / busy     req_command, req_file_id, req_peer_id
// response  rsp_valid        rsp_listed_peer, rsp_list_length, rsp_last_item, rsp_status
//
// A register request keeps busy high for one cycle; its single response follows in the next.
// A peer request scans the list, bumps the head peer's counter, appends the peer if absent,
// sorts the list by counter and emits it, using the one list read port and the list-then-counter
// read chain per compare. Reset is synchronous; valid bits clear lengths and counters at once.
// Responses come one per cycle and cannot be stalled; busy stays high until the last.
module least_requested_peer_tracker #(
   parameter int FILE_SLOTS = 16,
   parameter int PEER_SLOTS = 64,
   parameter int COUNT_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_command,
   input  logic [3:0]                        req_file_id,
   input  logic [lrpt_pkg::PEER_BITS-1:0]    req_peer_id,
   output logic                              rsp_valid,
   output logic [lrpt_pkg::PEER_BITS-1:0]    rsp_listed_peer,
   output logic [lrpt_pkg::LEN_OUT_BITS-1:0] rsp_list_length,
   output logic                              rsp_last_item,
   output logic                              rsp_status
);
   import lrpt_pkg::*;

   localparam int SB = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
   localparam int LB = $clog2(PEER_SLOTS + 1);
   localparam int IB = $clog2(PEER_SLOTS);
   localparam int LA = $clog2(FILE_SLOTS * PEER_SLOTS);
   localparam int CA = $clog2(PEER_IDS);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_LEN      = 4'd1;
   localparam logic [3:0] S_SCAN     = 4'd2;
   localparam logic [3:0] S_HEAD_RD  = 4'd3;
   localparam logic [3:0] S_HEAD_WR  = 4'd4;
   localparam logic [3:0] S_APPEND   = 4'd5;
   localparam logic [3:0] S_SORT_CHK = 4'd6;
   localparam logic [3:0] S_A_RD     = 4'd7;
   localparam logic [3:0] S_A_PEER   = 4'd8;
   localparam logic [3:0] S_A_CNT    = 4'd9;
   localparam logic [3:0] S_B_PEER   = 4'd10;
   localparam logic [3:0] S_B_CNT    = 4'd11;
   localparam logic [3:0] S_A_WB     = 4'd12;
   localparam logic [3:0] S_EMIT_RD  = 4'd13;
   localparam logic [3:0] S_EMIT     = 4'd14;

   logic [3:0]            state_ff, state_in;
   logic                  cmd_ff, cmd_in;
   logic [SB-1:0]         slot_ff, slot_in, slot_req;
   logic [PEER_BITS-1:0]  peer_ff, peer_in;
   logic [LB-1:0]         len_ff, len_in;
   logic [LB-1:0]         idx_ff, idx_in;
   logic [LB-1:0]         row_ff, row_in;
   logic [PEER_BITS-1:0]  head_ff, head_in;
   logic                  present_ff, present_in;
   logic                  stat_ff, stat_in;
   logic [PEER_BITS-1:0]  a_peer_ff, a_peer_in;
   logic [COUNT_BITS-1:0] a_cnt_ff, a_cnt_in;
   logic [PEER_BITS-1:0]  b_peer_ff, b_peer_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [PEER_BITS-1:0]    rsp_peer_ff, rsp_peer_in;
   logic [LEN_OUT_BITS-1:0] rsp_len_ff, rsp_len_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_stat_ff, rsp_stat_in;

   logic                  list_we;
   logic [LB-1:0]         list_widx, list_ridx;
   logic [PEER_BITS-1:0]  list_wdata, list_rdata;
   logic [LA-1:0]         list_waddr, list_raddr, list_base;

   logic                  len_we;
   logic [SB-1:0]         len_raddr;
   logic [LB-1:0]         len_wdata, len_rdata;

   logic                  cnt_we;
   logic [CA-1:0]         cnt_raddr;
   logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;

   logic                  accept;
   logic [LB-1:0]         idx_next, len_next;

   assign accept    = start && !busy;
   assign idx_next  = LB'(idx_ff + LB'(1));
   assign list_base = LA'(LA'(slot_ff) * LA'(PEER_SLOTS));
   assign list_waddr = LA'(list_base + LA'(list_widx[IB-1:0]));
   assign list_raddr = LA'(list_base + LA'(list_ridx[IB-1:0]));

   always_comb begin
      slot_req = '0;
      for (int v = 0; v < 16; v++) begin
         if (req_file_id == 4'(v)) begin
            slot_req = SB'(v % FILE_SLOTS);
         end
      end
   end

   lrpt_list_ram #(.DEPTH(FILE_SLOTS * PEER_SLOTS), .AW(LA)) u_list (
      .clock (clock),
      .we    (list_we),
      .waddr (list_waddr),
      .wdata (list_wdata),
      .raddr (list_raddr),
      .rdata (list_rdata)
   );

   lrpt_vram #(.WIDTH(LB), .DEPTH(FILE_SLOTS), .AW(SB)) u_lengths (
      .clock (clock),
      .reset (reset),
      .we    (len_we),
      .waddr (slot_ff),
      .wdata (len_wdata),
      .raddr (len_raddr),
      .rdata (len_rdata)
   );

   lrpt_vram #(.WIDTH(COUNT_BITS), .DEPTH(PEER_IDS), .AW(CA)) u_counts (
      .clock (clock),
      .reset (reset),
      .we    (cnt_we),
      .waddr (head_ff),
      .wdata (cnt_wdata),
      .raddr (cnt_raddr),
      .rdata (cnt_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      slot_in      = slot_ff;
      peer_in      = peer_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      row_in       = row_ff;
      head_in      = head_ff;
      present_in   = present_ff;
      stat_in      = stat_ff;
      a_peer_in    = a_peer_ff;
      a_cnt_in     = a_cnt_ff;
      b_peer_in    = b_peer_ff;
      rsp_valid_in = 1'b0;
      rsp_peer_in  = rsp_peer_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_stat_in  = rsp_stat_ff;
      list_we      = 1'b0;
      list_widx    = idx_ff;
      list_wdata   = peer_ff;
      list_ridx    = idx_ff;
      len_we       = 1'b0;
      len_raddr    = slot_req;
      len_wdata    = LB'(len_ff + LB'(1));
      cnt_we       = 1'b0;
      cnt_raddr    = head_ff;
      cnt_wdata    = (cnt_rdata == '1) ? cnt_rdata : COUNT_BITS'(cnt_rdata + 1'b1);
      len_next     = len_rdata;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in     = req_command;
               slot_in    = slot_req;
               peer_in    = req_peer_id;
               present_in = 1'b0;
               stat_in    = STATUS_OK;
               state_in   = S_LEN;
            end
         end
         S_LEN: begin
            len_in = len_rdata;
            idx_in = '0;
            list_ridx = '0;
            if (cmd_ff == CMD_REGISTER) begin
               if (len_rdata == LB'(PEER_SLOTS)) begin
                  rsp_stat_in = STATUS_FULL;
               end else begin
                  list_we     = 1'b1;
                  list_widx   = len_rdata;
                  len_we      = 1'b1;
                  len_wdata   = LB'(len_rdata + LB'(1));
                  len_next    = len_wdata;
                  rsp_stat_in = STATUS_OK;
               end
               rsp_valid_in = 1'b1;
               rsp_peer_in  = '0;
               rsp_len_in   = LEN_OUT_BITS'(len_next);
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end else if (len_rdata == '0) begin
               state_in = S_APPEND;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (idx_ff == '0) begin
               head_in = list_rdata;
            end
            if (list_rdata == peer_ff) begin
               present_in = 1'b1;
            end
            list_ridx = idx_next;
            if (idx_next < len_ff) begin
               idx_in = idx_next;
            end else begin
               state_in = S_HEAD_RD;
            end
         end
         S_HEAD_RD: begin
            state_in = S_HEAD_WR;
         end
         S_HEAD_WR: begin
            cnt_we   = 1'b1;
            state_in = S_APPEND;
         end
         S_APPEND: begin
            if (!present_ff) begin
               if (len_ff == LB'(PEER_SLOTS)) begin
                  stat_in = STATUS_FULL;
               end else begin
                  list_we   = 1'b1;
                  list_widx = len_ff;
                  len_we    = 1'b1;
                  len_in    = LB'(len_ff + LB'(1));
               end
            end
            state_in = S_SORT_CHK;
         end
         S_SORT_CHK: begin
            row_in = '0;
            idx_in = '0;
            if (len_ff >= LB'(2)) begin
               state_in = S_A_RD;
            end else if (len_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_peer_in  = '0;
               rsp_len_in   = '0;
               rsp_last_in  = 1'b1;
               rsp_stat_in  = stat_ff;
               state_in     = S_IDLE;
            end else begin
               state_in = S_EMIT_RD;
            end
         end
         S_A_RD: begin
            list_ridx = row_ff;
            state_in  = S_A_PEER;
         end
         S_A_PEER: begin
            a_peer_in = list_rdata;
            cnt_raddr = list_rdata;
            state_in  = S_A_CNT;
         end
         S_A_CNT: begin
            a_cnt_in  = cnt_rdata;
            idx_in    = LB'(row_ff + LB'(1));
            list_ridx = LB'(row_ff + LB'(1));
            state_in  = S_B_PEER;
         end
         S_B_PEER: begin
            b_peer_in = list_rdata;
            cnt_raddr = list_rdata;
            state_in  = S_B_CNT;
         end
         S_B_CNT: begin
            if (a_cnt_ff > cnt_rdata) begin
               list_we    = 1'b1;
               list_widx  = idx_ff;
               list_wdata = a_peer_ff;
               a_peer_in  = b_peer_ff;
               a_cnt_in   = cnt_rdata;
            end
            list_ridx = idx_next;
            if (idx_next < len_ff) begin
               idx_in   = idx_next;
               state_in = S_B_PEER;
            end else begin
               state_in = S_A_WB;
            end
         end
         S_A_WB: begin
            list_we    = 1'b1;
            list_widx  = row_ff;
            list_wdata = a_peer_ff;
            if (LB'(row_ff + LB'(2)) < len_ff) begin
               row_in   = LB'(row_ff + LB'(1));
               state_in = S_A_RD;
            end else begin
               idx_in   = '0;
               state_in = S_EMIT_RD;
            end
         end
         S_EMIT_RD: begin
            list_ridx = '0;
            idx_in    = '0;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_peer_in  = list_rdata;
            rsp_len_in   = LEN_OUT_BITS'(len_ff);
            rsp_last_in  = (idx_next == len_ff);
            rsp_stat_in  = stat_ff;
            list_ridx    = idx_next;
            if (idx_next < len_ff) begin
               idx_in = idx_next;
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      slot_ff     <= slot_in;
      peer_ff     <= peer_in;
      len_ff      <= len_in;
      idx_ff      <= idx_in;
      row_ff      <= row_in;
      head_ff     <= head_in;
      present_ff  <= present_in;
      stat_ff     <= stat_in;
      a_peer_ff   <= a_peer_in;
      a_cnt_ff    <= a_cnt_in;
      b_peer_ff   <= b_peer_in;
      rsp_peer_ff <= rsp_peer_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_last_ff <= rsp_last_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_listed_peer = rsp_peer_ff;
   assign rsp_list_length = rsp_len_ff;
   assign rsp_last_item   = rsp_last_ff;
   assign rsp_status      = rsp_stat_ff;

   // A request that is taken always makes the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset) accept |=> busy)
      else $error("accepted request did not raise busy");

   // The responses of one request come in consecutive cycles.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_item |=> rsp_valid)
      else $error("gap inside a response burst");

   // A burst ends cleanly: no response right after the last one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_item |=> !rsp_valid)
      else $error("response right after the last item");

   // A list never grows beyond its capacity.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_list_length <= LEN_OUT_BITS'(PEER_SLOTS)))
      else $error("list length beyond capacity");

endmodule
